// File: rtl/pmg_pkg.sv
// ----------------------------------------------------------------------------
// pmg_pkg
// shared types and constants of the pseudo-color map generator
// ----------------------------------------------------------------------------
package pmg_pkg;

  localparam int unsigned MaxColorsDef = 256;
  localparam int unsigned NumW   = 9;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned RemW   = 16;
  localparam int unsigned QuoW   = 8;
  localparam int unsigned Lanes  = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [NumW-1:0] NumColorsRst = 9'd256;

  typedef enum logic [1:0] {
    MAP_HOT  = 2'd0,
    MAP_JET  = 2'd1,
    MAP_GRAY = 2'd2,
    MAP_BAD  = 2'd3
  } map_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_KIND  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_NUM_COLORS = 1'b0,
    REG_MAP_KIND   = 1'b1
  } reg_idx_t;

  // one request in flight through the divider chain, one lane per channel
  typedef struct packed {
    logic [Lanes-1:0][RemW-1:0] rem;
    logic [Lanes-1:0][NumW-1:0] den;
    logic [Lanes-1:0][QuoW-1:0] quo;
    status_t                    status;
  } div_t;

endpackage

// File: rtl/pmg_front.sv
// ----------------------------------------------------------------------------
// pmg_front
// segment select and numerator/denominator setup, one register stage
// ----------------------------------------------------------------------------
module pmg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [pmg_pkg::IdxW-1:0]     color_index,
  input  logic [pmg_pkg::NumW-1:0]     num_colors,
  input  pmg_pkg::map_kind_t           map_kind,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output pmg_pkg::div_t                dn_data
);

  logic          valid_r;
  pmg_pkg::div_t data_r;
  pmg_pkg::div_t data_nxt;

  logic [9:0] iw, nw, band, b2, q, e, eq, e2q, ne, m, d;
  logic [10:0] three_n;
  logic [pmg_pkg::Lanes-1:0][9:0] lnum;
  logic [pmg_pkg::Lanes-1:0][9:0] lden;
  logic [16:0] prod;
  pmg_pkg::status_t st;

  always_comb begin
    iw      = {2'b00, color_index};
    nw      = {1'b0, num_colors};
    three_n = {1'b0, nw} + {nw, 1'b0};
    band    = {2'b00, three_n[10:3]};
    b2      = {band[8:0], 1'b0};
    q       = nw >> 2;
    e       = nw >> 3;
    eq      = e + q;
    e2q     = eq + q;
    ne      = nw - e;
    m       = nw - {e[8:0], 1'b0} - {q[8:0], 1'b0};
    d       = '0;
    prod    = '0;
    for (int k = 0; k < 3; k++) begin
      lnum[k] = 10'd0;
      lden[k] = 10'd1;
    end

    if (map_kind == pmg_pkg::MAP_BAD) begin
      st = pmg_pkg::ST_KIND;
    end else if (iw >= nw) begin
      st = pmg_pkg::ST_RANGE;
    end else begin
      st = pmg_pkg::ST_OK;
    end

    // lane 0 red, 1 green, 2 blue; full level is 1/1, zero is 0/1
    case (map_kind)
      pmg_pkg::MAP_HOT: begin
        if (iw < band) begin
          lnum[0] = iw + 10'd1; lden[0] = band;
        end else if (iw < b2) begin
          lnum[0] = 10'd1;
          lnum[1] = iw - band + 10'd1; lden[1] = band;
        end else begin
          lnum[0] = 10'd1;
          lnum[1] = 10'd1;
          lnum[2] = iw - b2 + 10'd1; lden[2] = nw - b2;
        end
      end
      pmg_pkg::MAP_JET: begin
        if (iw < e) begin
          lnum[2] = e + iw; lden[2] = {e[8:0], 1'b0};
        end else if (iw < eq) begin
          lnum[1] = iw - e; lden[1] = q;
          lnum[2] = 10'd1;
        end else if (iw < e2q) begin
          d = iw - eq;
          lnum[0] = d;      lden[0] = q;
          lnum[1] = 10'd1;
          lnum[2] = q - d;  lden[2] = q;
        end else if (iw < ne) begin
          d = iw - e2q;
          lnum[0] = 10'd1;
          lnum[1] = m - d;  lden[1] = m;
        end else begin
          d = iw - ne;
          lnum[0] = {e[8:0], 1'b0} - d; lden[0] = {e[8:0], 1'b0};
        end
      end
      pmg_pkg::MAP_GRAY: begin
        for (int k = 0; k < 3; k++) begin
          lnum[k] = iw;
          lden[k] = nw - 10'd1;
        end
      end
      default: begin
        st = pmg_pkg::ST_KIND;
      end
    endcase

    data_nxt.status = st;
    data_nxt.quo    = '0;
    for (int k = 0; k < 3; k++) begin
      // zero denominator or a flagged request gives a zero level
      if (st != pmg_pkg::ST_OK || lden[k] == 10'd0) begin
        lnum[k] = 10'd0;
        lden[k] = 10'd1;
      end
      prod = {lnum[k][8:0], 8'd0} - {8'd0, lnum[k][8:0]};
      data_nxt.rem[k] = prod[15:0];
      data_nxt.den[k] = lden[k][8:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/pmg_div_cell.sv
// ----------------------------------------------------------------------------
// pmg_div_cell
// one restoring-division step per lane, resolves one quotient bit
// ----------------------------------------------------------------------------
module pmg_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  pmg_pkg::div_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output pmg_pkg::div_t dn_data
);

  logic          valid_r;
  pmg_pkg::div_t data_r;
  pmg_pkg::div_t data_nxt;
  logic [16:0]   dsh;
  logic [16:0]   rw;

  always_comb begin
    data_nxt = up_data;
    dsh      = '0;
    rw       = '0;
    for (int k = 0; k < 3; k++) begin
      dsh = {8'd0, up_data.den[k]} << BIT;
      rw  = {1'b0, up_data.rem[k]};
      if (rw >= dsh) begin
        rw = rw - dsh;
        data_nxt.quo[k][BIT] = 1'b1;
      end
      data_nxt.rem[k] = rw[15:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/pseudocolor_map_generator_core.sv
// ----------------------------------------------------------------------------
// pseudocolor_map_generator_core
// hot, jet and gray pseudo-color map over a configured number of colors
// ----------------------------------------------------------------------------
// One color index is taken every clock cycle while the pipe is not stalled;
// its red, green and blue levels leave once one setup stage has picked the
// segment of the map and a row of 8 divider cells has resolved one quotient
// bit each, for all three channels side by side. Each stage holds its
// request until the next is free, so gaps in the stream close under output stalls.
module pseudocolor_map_generator_core #(
  parameter int unsigned MAX_COLORS = pmg_pkg::MaxColorsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pmg_pkg::AddrW-1:0]  paddr,
  input  logic [pmg_pkg::DataW-1:0]  pwdata,
  output logic [pmg_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pmg_pkg::IdxW-1:0]   in_color_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_red_level,
  output logic [7:0]                 out_green_level,
  output logic [7:0]                 out_blue_level,
  output logic [1:0]                 out_status
);

  localparam int unsigned Cells = pmg_pkg::QuoW;

  logic [pmg_pkg::NumW-1:0] num_colors_r;
  pmg_pkg::map_kind_t       map_kind_r;
  logic [pmg_pkg::NumW-1:0] n_eff;
  pmg_pkg::reg_idx_t        reg_sel;
  logic                     wr_en;

  pmg_pkg::div_t st_data  [Cells+1];
  logic          st_valid [Cells+1];
  logic          st_ready [Cells+1];

  assign pready  = 1'b1;
  assign reg_sel = pmg_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_colors_r <= pmg_pkg::NumColorsRst;
      map_kind_r   <= pmg_pkg::MAP_HOT;
    end else if (wr_en) begin
      case (reg_sel)
        pmg_pkg::REG_NUM_COLORS: num_colors_r <= pwdata[pmg_pkg::NumW-1:0];
        pmg_pkg::REG_MAP_KIND:   map_kind_r   <= pmg_pkg::map_kind_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pmg_pkg::REG_NUM_COLORS: prdata = {23'd0, num_colors_r};
      pmg_pkg::REG_MAP_KIND:   prdata = {30'd0, map_kind_r};
      default:                 prdata = '0;
    endcase
  end

  // count saturates at the largest supported map
  assign n_eff = ({23'd0, num_colors_r} > MAX_COLORS) ? pmg_pkg::NumW'(MAX_COLORS)
                                                      : num_colors_r;

  pmg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .color_index (in_color_index),
    .num_colors  (n_eff),
    .map_kind    (map_kind_r),
    .dn_valid    (st_valid[0]),
    .dn_ready    (st_ready[0]),
    .dn_data     (st_data[0])
  );

  for (genvar c = 0; c < Cells; c++) begin : g_cell
    pmg_div_cell #(
      .BIT (Cells - 1 - c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[c]),
      .up_ready (st_ready[c]),
      .up_data  (st_data[c]),
      .dn_valid (st_valid[c+1]),
      .dn_ready (st_ready[c+1]),
      .dn_data  (st_data[c+1])
    );
  end

  assign st_ready[Cells]  = out_ready;
  assign out_valid        = st_valid[Cells];
  assign out_red_level    = st_data[Cells].quo[0];
  assign out_green_level  = st_data[Cells].quo[1];
  assign out_blue_level   = st_data[Cells].quo[2];
  assign out_status       = st_data[Cells].status;

endmodule

// File: tb/sv/tb_pseudocolor_map_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pseudocolor_map_generator_core
// self-checking bench for the hot, jet and gray pseudo-color map core
// ----------------------------------------------------------------------------
// The color count and the map kind are set over the register port while the
// core is idle. A table of directed requests covers the map extremes and the
// error cases, then random requests run under several register settings.
// Each result is checked against a typed expectation or a color map predictor
// in the bench, with random idle bursts on both sides outside the last phase.
module tb_pseudocolor_map_generator_core;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    pmg_pkg::status_t st;
  } color_t;

  typedef struct {
    logic [8:0]         ncol;
    pmg_pkg::map_kind_t kind;
    logic [7:0]         idx;
    bit                 typed;
    color_t             want;
  } row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [pmg_pkg::AddrW-1:0]   paddr = '0;
  logic [pmg_pkg::DataW-1:0]   pwdata = '0;
  logic [pmg_pkg::DataW-1:0]   prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [pmg_pkg::IdxW-1:0]    in_color_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_red_level;
  logic [7:0]                  out_green_level;
  logic [7:0]                  out_blue_level;
  logic [1:0]                  out_status;

  color_t              color_q[$];
  logic [8:0]          cur_ncol;
  pmg_pkg::map_kind_t  cur_kind;
  int                  mismatches = 0;
  int                  colors_seen = 0;
  int                  requests_sent = 0;
  int                  stall_cycles = 0;
  int                  settings_used = 1;
  bit                  quiet = 1'b0;
  row_t                rows[$];

  always #10 clk = ~clk;

  pseudocolor_map_generator_core DUT (.*);

  function automatic int unsigned ramp(int unsigned num, int unsigned den);
    if (den == 0) return 0;
    return (255 * num) / den;
  endfunction

  function automatic color_t map_color(logic [8:0] ncol, pmg_pkg::map_kind_t kind,
                                       logic [7:0] idx);
    color_t      c;
    int unsigned n, i, r, g, b, band, q, e, d, m;
    n = ncol;
    i = idx;
    r = 0; g = 0; b = 0;
    c.st = pmg_pkg::ST_OK;
    if (n > pmg_pkg::MaxColorsDef) n = pmg_pkg::MaxColorsDef;
    if (kind == pmg_pkg::MAP_BAD) begin
      c.st = pmg_pkg::ST_KIND;
    end else if (i >= n) begin
      c.st = pmg_pkg::ST_RANGE;
    end else if (kind == pmg_pkg::MAP_HOT) begin
      band = (n * 3) / 8;
      if (i < band) begin
        r = ramp(i + 1, band);
      end else if (i < 2 * band) begin
        r = 255; g = ramp(i - band + 1, band);
      end else begin
        r = 255; g = 255; b = ramp(i - 2 * band + 1, n - 2 * band);
      end
    end else if (kind == pmg_pkg::MAP_JET) begin
      q = n / 4;
      e = n / 8;
      if (i < e) begin
        b = ramp(e + i, 2 * e);
      end else if (i < e + q) begin
        g = ramp(i - e, q); b = 255;
      end else if (i < e + 2 * q) begin
        d = i - e - q;
        r = ramp(d, q); g = 255; b = ramp(q - d, q);
      end else if (i < n - e) begin
        d = i - e - 2 * q;
        m = n - 2 * e - 2 * q;
        r = 255; g = ramp(m - d, m);
      end else begin
        d = i - (n - e);
        r = ramp(2 * e - d, 2 * e);
      end
    end else begin
      r = (n > 1) ? ramp(i, n - 1) : 0;
      g = r; b = r;
    end
    c.red = r[7:0];
    c.green = g[7:0];
    c.blue = b[7:0];
    return c;
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    $display("mismatch on %s: got %0d, expected %0d (result %0d)",
             what, got, want, colors_seen);
  endtask

  // result side: random stalls, check against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          color_t w;
          w = color_q.pop_front();
          if (out_red_level !== w.red) report("red", out_red_level, w.red);
          if (out_green_level !== w.green) report("green", out_green_level, w.green);
          if (out_blue_level !== w.blue) report("blue", out_blue_level, w.blue);
          if (out_status !== w.st) report("status", out_status, w.st);
        end
        colors_seen++;
      end
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= (stall_cycles == 0);
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_cycles = $urandom_range(1, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request and no result accepted
  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= 5000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(pmg_pkg::reg_idx_t which, logic [pmg_pkg::DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_map(logic [8:0] ncol, pmg_pkg::map_kind_t kind);
    drain();
    reg_write(pmg_pkg::REG_NUM_COLORS, pmg_pkg::DataW'(ncol));
    reg_write(pmg_pkg::REG_MAP_KIND, pmg_pkg::DataW'(kind));
    cur_ncol = ncol;
    cur_kind = kind;
    settings_used++;
  endtask

  // valid stays high across back-to-back requests
  task automatic send(logic [7:0] idx, color_t want);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_color_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    color_q.push_back(want);
    requests_sent++;
  endtask

  function automatic row_t mk(logic [8:0] n, pmg_pkg::map_kind_t k, logic [7:0] i, bit t,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              pmg_pkg::status_t s);
    row_t x;
    x.ncol = n; x.kind = k; x.idx = i; x.typed = t;
    x.want = '{red: r, green: g, blue: b, st: s};
    return x;
  endfunction

  typedef struct { logic [8:0] n; pmg_pkg::map_kind_t k; } setting_t;

  initial begin
    setting_t   plan[$];
    int         per_phase;
    int         n_eff;
    logic [7:0] idx;
    color_t     w;

    cur_ncol = pmg_pkg::NumColorsRst;
    cur_kind = pmg_pkg::MAP_HOT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first: hot over 256 colors
    rows.push_back(mk(256, pmg_pkg::MAP_HOT, 0,   0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_HOT, 255, 1, 255, 255, 255, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_HOT, 95,  0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_HOT, 96,  0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_HOT, 192, 0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_JET, 0,   0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_JET, 32,  0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_JET, 96,  0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_JET, 160, 0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_JET, 224, 0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_JET, 255, 0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_GRAY, 0,   1, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_GRAY, 255, 1, 255, 255, 255, pmg_pkg::ST_OK));
    rows.push_back(mk(256, pmg_pkg::MAP_BAD, 7,    1, 0, 0, 0, pmg_pkg::ST_KIND));
    rows.push_back(mk(1, pmg_pkg::MAP_GRAY, 0,     1, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(1, pmg_pkg::MAP_GRAY, 1,     1, 0, 0, 0, pmg_pkg::ST_RANGE));
    rows.push_back(mk(1, pmg_pkg::MAP_HOT, 0,      0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(1, pmg_pkg::MAP_JET, 0,      0, 0, 0, 0, pmg_pkg::ST_OK));
    rows.push_back(mk(0, pmg_pkg::MAP_HOT, 0,      1, 0, 0, 0, pmg_pkg::ST_RANGE));
    rows.push_back(mk(0, pmg_pkg::MAP_BAD, 0,      1, 0, 0, 0, pmg_pkg::ST_KIND));
    rows.push_back(mk(100, pmg_pkg::MAP_JET, 255,  1, 0, 0, 0, pmg_pkg::ST_RANGE));
    rows.push_back(mk(511, pmg_pkg::MAP_GRAY, 255, 1, 255, 255, 255, pmg_pkg::ST_OK));
    rows.push_back(mk(511, pmg_pkg::MAP_HOT, 128,  0, 0, 0, 0, pmg_pkg::ST_OK));

    foreach (rows[k]) begin
      if (rows[k].ncol != cur_ncol || rows[k].kind != cur_kind)
        set_map(rows[k].ncol, rows[k].kind);
      w = rows[k].typed ? rows[k].want : map_color(cur_ncol, cur_kind, rows[k].idx);
      send(rows[k].idx, w);
    end

    plan.push_back('{256, pmg_pkg::MAP_HOT});
    plan.push_back('{256, pmg_pkg::MAP_JET});
    plan.push_back('{256, pmg_pkg::MAP_GRAY});
    plan.push_back('{1, pmg_pkg::MAP_JET});
    plan.push_back('{0, pmg_pkg::MAP_GRAY});
    plan.push_back('{7, pmg_pkg::MAP_JET});
    plan.push_back('{511, pmg_pkg::MAP_BAD});
    plan.push_back('{9'($urandom_range(2, 255)), pmg_pkg::MAP_HOT});
    plan.push_back('{9'($urandom_range(2, 255)), pmg_pkg::MAP_JET});
    plan.push_back('{9'($urandom_range(2, 255)),
                     pmg_pkg::map_kind_t'($urandom_range(0, 2))});
    per_phase = 165;

    foreach (plan[p]) begin
      set_map(plan[p].n, plan[p].k);
      quiet = (p == plan.size() - 1);
      n_eff = (cur_ncol > pmg_pkg::MaxColorsDef) ? pmg_pkg::MaxColorsDef : cur_ncol;
      for (int j = 0; j < per_phase; j++) begin
        if (n_eff > 0 && $urandom_range(0, 9) < 7) idx = 8'($urandom_range(0, n_eff - 1));
        else idx = 8'($urandom_range(0, 255));
        send(idx, map_color(cur_ncol, cur_kind, idx));
        // sender holds off until the pipe is empty once, in the middle of the third phase
        if (p == 2 && j == per_phase / 2) begin
          in_valid <= 1'b0;
          while (color_q.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d requests over %0d map settings, %0d results checked",
             requests_sent, settings_used, colors_seen);
    $display("hot, jet, gray and invalid kinds, color counts from 0 to 511");
    if (mismatches == 0 && color_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
